@@ sv/indexed_list_table_defines.svh @@
// Assertion macros for the indexed list table.
`ifndef INDEXED_LIST_TABLE_DEFINES_SVH
`define INDEXED_LIST_TABLE_DEFINES_SVH

// Checked at every clock edge outside reset.
`define ILT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Consequent checked in the cycle after the antecedent, outside reset.
`define ILT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/ilt_pkg.sv @@
package ilt_pkg;

  // Default sizes
  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int KIND_W    = 4;
  localparam int POS_W     = 7;
  localparam int AMT_W     = 7;
  localparam int FOUND_W   = 6;
  localparam int STATUS_W  = 3;
  localparam int ENTRIES_W = 7;
  localparam int LIMIT_W   = 7;

  // Configuration space
  localparam int PADDR_W = 3;
  localparam logic [LIMIT_W-1:0] SIZE_LIMIT_RST = 7'd64;
  localparam logic REG_SIZE_LIMIT = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    K_INSERT     = 4'd0,
    K_REMOVE     = 4'd1,
    K_READ       = 4'd2,
    K_WRITE      = 4'd3,
    K_FIND       = 4'd4,
    K_MAX        = 4'd5,
    K_MIN        = 4'd6,
    K_CLEAR      = 4'd7,
    K_DROP_FIRST = 4'd8,
    K_DROP_LAST  = 4'd9
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    S_OK       = 3'd0,
    S_EMPTY    = 3'd1,
    S_FULL     = 3'd2,
    S_BADIDX   = 3'd3,
    S_NOTFOUND = 3'd4,
    S_TOOMANY  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

endpackage

@@ sv/indexed_list_table.sv @@
// Operations without a memory walk (write, clear, drop last, trivial drop first, errors,
// append) give their result in the cycle after start; walks read each entry through the
// registered read port, and insert with shift-up ends with a write state (ST_FIN). Only one
// operation runs at a time. The walk rate is one entry per cycle through the store's read port.
// Reset: live count cleared, size_limit set to 64; store contents are not cleared.
`include "indexed_list_table_defines.svh"

module indexed_list_table
  import ilt_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [KIND_W-1:0]            kind,
  input  logic [POS_W-1:0]             position,
  input  logic signed [DATA_WIDTH-1:0] word,
  input  logic [AMT_W-1:0]             amount,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] data,
  output logic [FOUND_W-1:0]           found_at,
  output logic [STATUS_W-1:0]          status,
  output logic [ENTRIES_W-1:0]         entries,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [PADDR_W-1:0]           paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CW    = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Registers
  state_t                         state, state_next;
  logic [CNT_W-1:0]               cnt, cnt_next;
  logic [LIMIT_W-1:0]             size_limit;
  kind_t                          op;
  logic signed [DATA_WIDTH-1:0]   word_q;
  logic [AW-1:0]                  pos_q;
  logic [AW-1:0]                  amt_q;
  logic [AW-1:0]                  rd_ptr;
  logic [CNT_W-1:0]               left;
  logic                           pend;
  logic [AW-1:0]                  pend_addr;
  logic signed [DATA_WIDTH-1:0]   acc, acc_next;
  logic signed [DATA_WIDTH-1:0]   mem [CAPACITY];
  logic signed [DATA_WIDTH-1:0]   rdata;

  // Combinational control
  kind_t                          k;
  logic                           accept;
  logic                           issue;
  logic                           last;
  logic                           empty;
  logic [CW-1:0]                  n_w, pos_w, amt_w, lim_w, pclamp, ins_top, diff;
  logic [CW-1:0]                  found_w;
  logic                           go_run, go_fin;
  logic [AW-1:0]                  run_ptr;
  logic [CNT_W-1:0]               run_len;
  logic                           wr_en;
  logic [AW-1:0]                  wr_addr;
  logic signed [DATA_WIDTH-1:0]   wr_data;
  logic                           resp_fire;
  status_t                        resp_status;
  logic signed [DATA_WIDTH-1:0]   resp_data;
  logic [AW-1:0]                  resp_found;
  logic                           cfg_wr;

  assign k      = kind_t'(kind);
  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign issue  = (state == ST_RUN) && (left != '0);
  assign last   = pend && (left == '0);
  assign empty  = (cnt == '0);

  // Operand scaling and limits
  assign n_w     = CW'(cnt);
  assign pos_w   = CW'(position);
  assign amt_w   = CW'(amount);
  assign lim_w   = (CW'(size_limit) < CW'(CAPACITY)) ? CW'(size_limit) : CW'(CAPACITY);
  assign pclamp  = (pos_w > n_w) ? n_w : pos_w;
  assign ins_top = n_w - CW'(1);
  assign diff    = n_w - ((k == K_INSERT) ? pclamp : (k == K_DROP_FIRST) ? amt_w : pos_w);
  assign found_w = CW'(resp_found);

  // Decode, walk processing, store write port and result
  always_comb begin
    go_run      = 1'b0;
    go_fin      = 1'b0;
    run_ptr     = '0;
    run_len     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = word;
    resp_fire   = 1'b0;
    resp_status = S_OK;
    resp_data   = '0;
    resp_found  = '0;
    cnt_next    = cnt;
    acc_next    = acc;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (k)
            K_INSERT: begin
              if (n_w >= lim_w) begin
                resp_fire   = 1'b1;
                resp_status = S_FULL;
              end else if (pclamp == n_w) begin
                // append: no shift needed
                wr_en     = 1'b1;
                wr_addr   = pclamp[AW-1:0];
                cnt_next  = cnt + CNT_W'(1);
                resp_fire = 1'b1;
              end else begin
                go_run  = 1'b1;
                run_ptr = ins_top[AW-1:0];
                run_len = diff[CNT_W-1:0];
              end
            end
            K_REMOVE, K_READ, K_WRITE: begin
              if (empty) begin
                resp_fire   = 1'b1;
                resp_status = S_EMPTY;
              end else if (pos_w >= n_w) begin
                resp_fire   = 1'b1;
                resp_status = S_BADIDX;
              end else if (k == K_WRITE) begin
                wr_en     = 1'b1;
                wr_addr   = pos_w[AW-1:0];
                resp_fire = 1'b1;
              end else begin
                go_run  = 1'b1;
                run_ptr = pos_w[AW-1:0];
                run_len = (k == K_READ) ? CNT_W'(1) : diff[CNT_W-1:0];
              end
            end
            K_FIND, K_MAX, K_MIN: begin
              if (empty) begin
                resp_fire   = 1'b1;
                resp_status = S_EMPTY;
              end else begin
                go_run  = 1'b1;
                run_ptr = '0;
                run_len = cnt;
              end
            end
            K_CLEAR: begin
              resp_fire = 1'b1;
              if (empty) begin
                resp_status = S_EMPTY;
              end else begin
                cnt_next = '0;
              end
            end
            K_DROP_FIRST, K_DROP_LAST: begin
              if (empty) begin
                resp_fire   = 1'b1;
                resp_status = S_EMPTY;
              end else if (amt_w > n_w) begin
                resp_fire   = 1'b1;
                resp_status = S_TOOMANY;
              end else if (k == K_DROP_LAST || amt_w == '0 || amt_w == n_w) begin
                cnt_next  = cnt - amt_w[CNT_W-1:0];
                resp_fire = 1'b1;
              end else begin
                go_run  = 1'b1;
                run_ptr = amt_w[AW-1:0];
                run_len = diff[CNT_W-1:0];
              end
            end
            default: begin
              resp_fire = 1'b1;
            end
          endcase
        end
      end
      ST_RUN: begin
        if (pend) begin
          case (op)
            K_INSERT: begin
              // shift up, walking down from the top
              wr_en   = 1'b1;
              wr_addr = pend_addr + AW'(1);
              wr_data = rdata;
              go_fin  = last;
            end
            K_REMOVE: begin
              if (pend_addr == pos_q) begin
                acc_next = rdata;
              end else begin
                wr_en   = 1'b1;
                wr_addr = pend_addr - AW'(1);
                wr_data = rdata;
              end
              if (last) begin
                resp_fire = 1'b1;
                resp_data = acc_next;
                cnt_next  = cnt - CNT_W'(1);
              end
            end
            K_READ: begin
              resp_fire = 1'b1;
              resp_data = rdata;
            end
            K_FIND: begin
              if (rdata == word_q) begin
                resp_fire  = 1'b1;
                resp_found = pend_addr;
              end else if (last) begin
                resp_fire   = 1'b1;
                resp_status = S_NOTFOUND;
              end
            end
            K_MAX, K_MIN: begin
              if (pend_addr == '0) begin
                acc_next = rdata;
              end else if ((op == K_MAX) ? (rdata > acc) : (rdata < acc)) begin
                acc_next = rdata;
              end
              if (last) begin
                resp_fire = 1'b1;
                resp_data = acc_next;
              end
            end
            K_DROP_FIRST: begin
              wr_en   = 1'b1;
              wr_addr = pend_addr - amt_q;
              wr_data = rdata;
              if (last) begin
                resp_fire = 1'b1;
                cnt_next  = cnt - CNT_W'(amt_q);
              end
            end
            default: begin
              resp_fire = 1'b1;
            end
          endcase
        end
      end
      ST_FIN: begin
        // place the new word after the shift
        wr_en     = 1'b1;
        wr_addr   = pos_q;
        wr_data   = word_q;
        cnt_next  = cnt + CNT_W'(1);
        resp_fire = 1'b1;
      end
      default: begin
        resp_fire = 1'b0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (go_run) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (go_fin) begin
          state_next = ST_FIN;
        end else if (resp_fire) begin
          state_next = ST_IDLE;
        end
      end
      ST_FIN: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata <= mem[rd_ptr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      done       <= 1'b0;
      pend       <= 1'b0;
      size_limit <= SIZE_LIMIT_RST;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= resp_fire;
      pend  <= issue;
      if (cfg_wr) size_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  // Walk registers and result words
  always_ff @(posedge clk) begin
    if (go_run) begin
      op      <= k;
      word_q  <= word;
      pos_q   <= pclamp[AW-1:0];
      amt_q   <= amt_w[AW-1:0];
      rd_ptr  <= run_ptr;
      left    <= run_len;
    end else if (issue) begin
      rd_ptr <= (op == K_INSERT) ? rd_ptr - AW'(1) : rd_ptr + AW'(1);
      left   <= left - CNT_W'(1);
    end
    pend_addr <= rd_ptr;
    acc       <= acc_next;
    if (resp_fire) begin
      data     <= resp_data;
      found_at <= found_w[FOUND_W-1:0];
      status   <= resp_status;
      entries  <= ENTRIES_W'(cnt_next);
    end
  end

  // Configuration port
  assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_SIZE_LIMIT);
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == REG_SIZE_LIMIT) ? 32'(size_limit) : 32'd0;

  // Checks
  `ILT_ASSERT(a_cnt_cap, cnt <= CNT_W'(CAPACITY), "live count above capacity")
  `ILT_ASSERT(a_done_idle, done |-> !busy, "result word while still busy")
  `ILT_ASSERT_NEXT(a_fin_done, state == ST_FIN, done, "insert finish gave no result word")

endmodule
